// ===== hw/rtl/grcf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grcf_pkg
// Shared widths, constants, register indexes and the queued item type for the
// gyro rate calibrate filter.
// ----------------------------------------------------------------------------
package grcf_pkg;

    localparam int CODE_W     = 10;   // width of one ADC code field
    localparam int RATE_W     = 28;   // Q20.8 rate
    localparam int GAIN_W     = 24;
    localparam int COEFF_W    = 17;
    localparam int SUM_W      = 32;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam int CAL_SAMPLES_DEF = 10;
    localparam int ADC_BITS_DEF    = 10;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(107000);
    localparam logic [COEFF_W-1:0] COEFF_RESET = COEFF_W'(65536);
    localparam logic [COEFF_W-1:0] COEFF_ONE   = COEFF_W'(65536);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_GAIN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEFF = 1'b1;

    typedef struct packed {
        logic              cal;
        logic [CODE_W-1:0] x_code;
        logic [CODE_W-1:0] y_code;
    } t_item;

endpackage
`default_nettype wire

// ===== hw/rtl/grcf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grcf_front
// Input stage: takes items off the input channel, masks the codes to the ADC
// width, tags calibration items and hands them to the queue.
// ----------------------------------------------------------------------------
module grcf_front #(
    parameter int ADC_BITS = grcf_pkg::ADC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_func,
    input  wire logic [grcf_pkg::CODE_W-1:0] i_x_code,
    input  wire logic [grcf_pkg::CODE_W-1:0] i_y_code,
    output logic                             o_push,
    output grcf_pkg::t_item                  o_item,
    input  wire logic                        i_q_full
);
    import grcf_pkg::*;

    localparam logic [CODE_W-1:0] CODE_MASK =
        (ADC_BITS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((1 << ADC_BITS) - 1);

    logic  r_valid;
    t_item r_item;
    logic  w_accept;

    assign o_in_stall = r_valid && i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.cal    <= i_func;
            r_item.x_code <= i_x_code & CODE_MASK;
            r_item.y_code <= i_y_code & CODE_MASK;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/grcf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grcf_queue
// Short item queue between the input stage and the execution unit.
// ----------------------------------------------------------------------------
module grcf_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire grcf_pkg::t_item i_item,
    output logic                 o_full,
    output logic                 o_valid,
    output grcf_pkg::t_item      o_item,
    input  wire logic            i_pop
);
    import grcf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_QW-1:0] DEPTH_C = CNT_QW'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0]  LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

    t_item             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == DEPTH_C);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_P) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_P) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/grcf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grcf_back
// Execution unit: one shared multiplier for gain and filter products, the
// offset/filter/calibration state, a reciprocal-multiply mean unit and the
// result register. Also holds the configuration registers.
// ----------------------------------------------------------------------------
module grcf_back #(
    parameter int CAL_SAMPLES = grcf_pkg::CAL_SAMPLES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [grcf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [grcf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_q_valid,
    input  wire grcf_pkg::t_item                 i_item,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic signed [grcf_pkg::RATE_W-1:0]   o_raw_rate_x,
    output logic signed [grcf_pkg::RATE_W-1:0]   o_raw_rate_y,
    output logic signed [grcf_pkg::RATE_W-1:0]   o_filt_rate_x,
    output logic signed [grcf_pkg::RATE_W-1:0]   o_filt_rate_y,
    output logic                                 o_calibrating,
    output logic                                 o_cal_done
);
    import grcf_pkg::*;

    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = RATE_W + 2;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int WIDE_W  = 40;
    localparam int DPROD_W = 2 * SUM_W;

    // mean = (sum + half) * ceil(2^sh / n) >> sh, exact for dividends below
    // 2^(SUM_W-1), which a sum of n saturated rates never reaches
    localparam int     RCP_SH = SUM_W - 1 + $clog2(CAL_SAMPLES);
    localparam longint RCP_L  = ((longint'(1) << RCP_SH) + longint'(CAL_SAMPLES) - 1)
                                / longint'(CAL_SAMPLES);

    localparam logic signed [WIDE_W-1:0] RATE_MAX_W = WIDE_W'((1 << (RATE_W - 1)) - 1);
    localparam logic signed [WIDE_W-1:0] RATE_MIN_W = -WIDE_W'(1 << (RATE_W - 1));
    localparam logic [CNT_W-1:0]  CAL_N    = CNT_W'(CAL_SAMPLES);
    localparam logic [SUM_W-1:0]  HALF     = SUM_W'(CAL_SAMPLES / 2);
    localparam logic [SUM_W-1:0]  RCP_M    = SUM_W'(RCP_L);
    localparam logic signed [PROD_W-1:0] ROUND_C = PROD_W'(32768);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GY   = 3'd1;
    localparam logic [2:0] S_FX   = 3'd2;
    localparam logic [2:0] S_FY   = 3'd3;
    localparam logic [2:0] S_FW   = 3'd4;
    localparam logic [2:0] S_CAL  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    function automatic logic signed [RATE_W-1:0] sat_rate(input logic signed [WIDE_W-1:0] v);
        logic signed [RATE_W-1:0] res;
        if (v > RATE_MAX_W) begin
            res = RATE_MAX_W[RATE_W-1:0];
        end else if (v < RATE_MIN_W) begin
            res = RATE_MIN_W[RATE_W-1:0];
        end else begin
            res = v[RATE_W-1:0];
        end
        return res;
    endfunction

    logic [2:0]                r_state;
    logic [GAIN_W-1:0]         r_gain;
    logic [COEFF_W-1:0]        r_coeff;
    logic signed [RATE_W-1:0]  r_off_x;
    logic signed [RATE_W-1:0]  r_off_y;
    logic signed [RATE_W-1:0]  r_filt_x;
    logic signed [RATE_W-1:0]  r_filt_y;
    logic [SUM_W-1:0]          r_sum_x;
    logic [SUM_W-1:0]          r_sum_y;
    logic [CNT_W-1:0]          r_cal_count;
    logic                      r_cal;
    logic                      r_done;
    logic [CODE_W-1:0]         r_code_y;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [RATE_W-1:0]  r_raw_x;
    logic signed [RATE_W-1:0]  r_raw_y;
    logic [SUM_W-1:0]          r_dq_x;
    logic [SUM_W-1:0]          r_dq_y;
    logic                      r_div_y;

    logic                      w_pop;
    logic                      w_out_free;
    logic [COEFF_W-1:0]        w_k;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic [RATE_W-1:0]         w_rate;
    logic signed [RATE_W-1:0]  w_off_sel;
    logic signed [RATE_W-1:0]  w_raw;
    logic signed [RATE_W:0]    w_fdiff_x;
    logic signed [RATE_W:0]    w_fdiff_y;
    logic signed [PROD_W-1:0]  w_fsum;
    logic signed [WIDE_W-2:0]  w_fstep;
    logic signed [RATE_W-1:0]  w_filt_sel;
    logic signed [RATE_W-1:0]  w_filt_new;
    logic [CNT_W-1:0]          w_cnt_inc;
    logic                      w_cal_last;
    logic [SUM_W-1:0]          w_sum_x_new;
    logic [SUM_W-1:0]          w_sum_y_new;
    logic [SUM_W-1:0]          w_div_n;
    logic [DPROD_W-1:0]        w_div_prod;
    logic signed [RATE_W-1:0]  w_mean;

    assign w_pop      = (r_state == S_IDLE) && i_q_valid;
    assign o_pop      = w_pop;
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_k        = (r_coeff > COEFF_ONE) ? COEFF_ONE : r_coeff;

    assign w_fdiff_x = (RATE_W + 1)'(r_raw_x) - (RATE_W + 1)'(r_filt_x);
    assign w_fdiff_y = (RATE_W + 1)'(r_raw_y) - (RATE_W + 1)'(r_filt_y);

    // shared multiplier: gain products first, then the two filter products
    always_comb begin
        case (r_state)
            S_IDLE: begin
                w_mul_a = MUL_A_W'({1'b0, r_gain});
                w_mul_b = MUL_B_W'({1'b0, i_item.x_code});
            end
            S_GY: begin
                w_mul_a = MUL_A_W'({1'b0, r_gain});
                w_mul_b = MUL_B_W'({1'b0, r_code_y});
            end
            S_FX: begin
                w_mul_a = MUL_A_W'({1'b0, w_k});
                w_mul_b = MUL_B_W'(w_fdiff_x);
            end
            S_FY: begin
                w_mul_a = MUL_A_W'({1'b0, w_k});
                w_mul_b = MUL_B_W'(w_fdiff_y);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // unsigned gain product clamps at the largest positive rate
    assign w_rate = (|r_prod[PROD_W-1:RATE_W-1]) ? RATE_MAX_W[RATE_W-1:0]
                                                 : r_prod[RATE_W-1:0];
    assign w_off_sel = (r_state == S_GY) ? r_off_x : r_off_y;
    assign w_raw = sat_rate(WIDE_W'($signed({1'b0, w_rate[RATE_W-2:0]}))
                            - WIDE_W'(w_off_sel));

    // round half up, then arithmetic shift by 16
    assign w_fsum     = r_prod + ROUND_C;
    assign w_fstep    = (WIDE_W - 1)'(w_fsum >>> 16);
    assign w_filt_sel = (r_state == S_FY) ? r_filt_x : r_filt_y;
    assign w_filt_new = sat_rate(WIDE_W'(w_filt_sel) + WIDE_W'(w_fstep));

    assign w_cnt_inc   = r_cal_count + 1'b1;
    assign w_cal_last  = (w_cnt_inc >= CAL_N);
    assign w_sum_x_new = r_sum_x + SUM_W'(r_raw_x[RATE_W-2:0]);
    assign w_sum_y_new = r_sum_y + SUM_W'(r_raw_y[RATE_W-2:0]);

    // mean of one axis per cycle, x first
    assign w_div_n    = r_div_y ? r_dq_y : r_dq_x;
    assign w_div_prod = DPROD_W'(w_div_n) * DPROD_W'(RCP_M);
    assign w_mean     = w_div_prod[RCP_SH+RATE_W-1:RCP_SH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RESET;
            r_coeff <= COEFF_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SCALE_GAIN:   r_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_FILTER_COEFF: r_coeff <= i_cfg_data[COEFF_W-1:0];
                default:          r_gain  <= r_gain;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_off_x     <= '0;
            r_off_y     <= '0;
            r_filt_x    <= '0;
            r_filt_y    <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_cal_count <= '0;
            r_done      <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        r_done <= 1'b0;
                        // first calibration item starts from a clean slate
                        if (i_item.cal && (r_cal_count == '0)) begin
                            r_off_x  <= '0;
                            r_off_y  <= '0;
                            r_filt_x <= '0;
                            r_filt_y <= '0;
                            r_sum_x  <= '0;
                            r_sum_y  <= '0;
                        end
                        r_state <= S_GY;
                    end
                end
                S_GY: r_state <= S_FX;
                S_FX: r_state <= r_cal ? S_CAL : S_FY;
                S_FY: begin
                    r_filt_x <= w_filt_new;
                    r_state  <= S_FW;
                end
                S_FW: begin
                    r_filt_y <= w_filt_new;
                    r_state  <= S_OUT;
                end
                S_CAL: begin
                    r_sum_x     <= w_sum_x_new;
                    r_sum_y     <= w_sum_y_new;
                    r_cal_count <= w_cal_last ? '0 : w_cnt_inc;
                    r_state     <= w_cal_last ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (!r_div_y) begin
                        r_off_x  <= w_mean;
                        r_filt_x <= w_mean;
                    end else begin
                        r_off_y  <= w_mean;
                        r_filt_y <= w_mean;
                        r_done   <= 1'b1;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_pop) begin
                    r_cal    <= i_item.cal;
                    r_code_y <= i_item.y_code;
                    r_prod   <= w_prod;
                end
            end
            S_GY: begin
                r_raw_x <= w_raw;
                r_prod  <= w_prod;
            end
            S_FX: begin
                r_raw_y <= w_raw;
                r_prod  <= w_prod;
            end
            S_FY: r_prod <= w_prod;
            S_CAL: begin
                r_dq_x  <= w_sum_x_new + HALF;
                r_dq_y  <= w_sum_y_new + HALF;
                r_div_y <= 1'b0;
            end
            S_DIV: r_div_y <= 1'b1;
            default: r_prod <= r_prod;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            o_raw_rate_x  <= r_raw_x;
            o_raw_rate_y  <= r_raw_y;
            o_filt_rate_x <= r_filt_x;
            o_filt_rate_y <= r_filt_y;
            o_calibrating <= (r_cal_count != '0);
            o_cal_done    <= r_done;
        end
    end

    a_count_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal_count < CAL_N)
        else $error("calibration count reached the sample count");

    a_offsets_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cal_count != '0) |-> (r_off_x == '0) && (r_off_y == '0))
        else $error("offset not cleared during calibration");

    a_done_ends_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cal_done) |-> !o_calibrating)
        else $error("calibration still flagged on completing result");

    a_div_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && r_div_y) |=> (r_state == S_OUT) && r_done)
        else $error("mean unit did not hand over to the result stage");

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (r_state == S_GY))
        else $error("item taken without starting the gain products");

endmodule
`default_nettype wire

// ===== hw/rtl/gyro_rate_calibrate_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gyro_rate_calibrate_filter
// Two-axis gyro rate conditioner: gain scaling, offset removal, low-pass
// filter and offset calibration by averaging calibration samples.
// ----------------------------------------------------------------------------
// Channels: i_in_valid / o_in_stall carries func, x_code, y_code; o_out_valid /
//   i_out_stall carries one result per item. A transfer happens on a clock edge
//   with valid high and stall low. Configuration writes (i_cfg_index 0
//   scale_gain, 1 filter_coeff) are always taken; write them only while idle.
// Timing: an input register and a two-entry queue feed an execution unit with
//   one shared multiplier, which takes one item at a time. A measure item passes
//   the states IDLE, GY, FX, FY, FW and OUT (two gain and two filter products),
//   a calibration item IDLE, GY, FX, CAL and OUT, and the item that completes a
//   calibration also DIV, once per axis, for the reciprocal multiplies of the means.
// Reset: synchronous, active low; offsets, filter state and sums cleared,
//   gain back to 107000 and coefficient to 1.0.
// Stall: a stalled result holds in the output register, the execution unit
//   waits, the queue fills and o_in_stall rises once the input register backs up.
// ----------------------------------------------------------------------------
module gyro_rate_calibrate_filter #(
    parameter int CAL_SAMPLES = grcf_pkg::CAL_SAMPLES_DEF,
    parameter int ADC_BITS    = grcf_pkg::ADC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [grcf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [grcf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_func,
    input  wire logic [grcf_pkg::CODE_W-1:0]     i_x_code,
    input  wire logic [grcf_pkg::CODE_W-1:0]     i_y_code,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic signed [grcf_pkg::RATE_W-1:0]   o_raw_rate_x,
    output logic signed [grcf_pkg::RATE_W-1:0]   o_raw_rate_y,
    output logic signed [grcf_pkg::RATE_W-1:0]   o_filt_rate_x,
    output logic signed [grcf_pkg::RATE_W-1:0]   o_filt_rate_y,
    output logic                                 o_calibrating,
    output logic                                 o_cal_done
);
    import grcf_pkg::*;

    logic  w_push;
    t_item w_front_item;
    logic  w_q_full;
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_pop;

    assign o_cfg_ready = 1'b1;

    grcf_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_func     (i_func),
        .i_x_code   (i_x_code),
        .i_y_code   (i_y_code),
        .o_push     (w_push),
        .o_item     (w_front_item),
        .i_q_full   (w_q_full)
    );

    grcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    grcf_back #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_valid     (w_q_valid),
        .i_item        (w_q_item),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_raw_rate_x  (o_raw_rate_x),
        .o_raw_rate_y  (o_raw_rate_y),
        .o_filt_rate_x (o_filt_rate_x),
        .o_filt_rate_y (o_filt_rate_y),
        .o_calibrating (o_calibrating),
        .o_cal_done    (o_cal_done)
    );

endmodule
`default_nettype wire
